>>> rtl/core/tgd_pkg.sv
// shared types, constants and codes of the touch gesture detector
package tgd_pkg;

    // default geometry
    localparam int TGD_SENSOR_COUNT      = 4;
    localparam int TGD_CHANNELS_PER_UNIT = 12;

    // fixed field widths
    localparam int TGD_SENSOR_W = 2;
    localparam int TGD_CHAN_W   = 4;
    localparam int TGD_MASK_W   = 12;
    localparam int TGD_TIME_W   = 32;
    localparam int TGD_MS_W     = 16;
    localparam int TGD_BYPASS_W = 48;
    localparam int TGD_EN_W     = 4;
    localparam int TGD_CFG_IDX_W = 3;

    // register reset values
    localparam logic [TGD_MS_W-1:0] TGD_LONG_PRESS_RST = 16'd300;
    localparam logic [TGD_MS_W-1:0] TGD_DOUBLE_TAP_RST = 16'd200;
    localparam logic [TGD_MS_W-1:0] TGD_DEBOUNCE_RST   = 16'd10;

    // event kinds
    typedef enum logic [1:0] {
        KIND_TOUCH   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_DOUBLE  = 2'd2,
        KIND_LONG    = 2'd3
    } t_kind;

    // configuration register indexes
    typedef enum logic [TGD_CFG_IDX_W-1:0] {
        CFG_LONG_PRESS = 3'd0,
        CFG_DOUBLE_TAP = 3'd1,
        CFG_DEBOUNCE   = 3'd2,
        CFG_BYPASS     = 3'd3,
        CFG_SENSOR_EN  = 3'd4
    } t_cfg_idx;

    // per-channel state entry
    typedef struct packed {
        logic                  touched;
        logic                  armed;
        logic                  win;
        logic                  adt;
        logic [TGD_TIME_W-1:0] pts;
        logic [TGD_TIME_W-1:0] rts;
    } t_entry;

    // timing thresholds
    typedef struct packed {
        logic [TGD_MS_W-1:0] long_ms;
        logic [TGD_MS_W-1:0] dtap_ms;
        logic [TGD_MS_W-1:0] deb_ms;
    } t_gest_cfg;

    // event kind with duration
    typedef struct packed {
        t_kind                 kind;
        logic [TGD_TIME_W-1:0] dur;
    } t_evk;

    // full event
    typedef struct packed {
        logic [TGD_SENSOR_W-1:0] sensor;
        logic [TGD_CHAN_W-1:0]   channel;
        t_kind                   kind;
        logic [TGD_TIME_W-1:0]   dur;
    } t_event;

    // token from the channel stage to the emitter
    typedef struct packed {
        logic   vld;
        logic   eoi;
        t_event ev;
    } t_tok;

endpackage

>>> rtl/core/tgd_mem.sv
// channel state memory, one write and one registered read port, write forwarding
module tgd_mem
    import tgd_pkg::*;
#(
    parameter int DEPTH  = TGD_SENSOR_COUNT * TGD_CHANNELS_PER_UNIT,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_entry            i_wdata,
    output t_entry            o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, same-cycle write to the read address is forwarded
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/tgd_chan.sv
// per-channel gesture update: new state entry and up to two events
module tgd_chan
    import tgd_pkg::*;
(
    input  t_entry                i_ent,
    input  logic                  i_touch,
    input  logic                  i_byp,
    input  logic [TGD_TIME_W-1:0] i_now,
    input  t_gest_cfg             i_cfg,
    output t_entry                o_ent,
    output logic [1:0]            o_ev_cnt,
    output t_evk                  o_ev0,
    output t_evk                  o_ev1
);

    logic [TGD_TIME_W-1:0] d_rel;
    logic [TGD_TIME_W-1:0] d_prs;
    logic [TGD_TIME_W-1:0] held;
    logic [TGD_TIME_W-1:0] gap;
    logic                  chg;
    logic                  pressed_now;
    logic                  released_now;
    logic                  dt_hit;
    logic                  long_hit;
    t_entry                ent;
    logic [1:0]            cnt;
    t_evk                  ev0;
    t_evk                  ev1;

    // time since last release and since last press, modulo 2^32
    assign d_rel = i_now - i_ent.rts;
    assign d_prs = i_now - i_ent.pts;

    // qualified edge
    assign chg          = (i_touch != i_ent.touched) && (d_rel > TGD_TIME_W'(i_cfg.deb_ms));
    assign pressed_now  = chg && i_touch;
    assign released_now = chg && !i_touch;

    // times against the updated timestamps
    assign held = pressed_now  ? '0 : d_prs;
    assign gap  = released_now ? '0 : d_rel;

    always_comb begin
        ent         = i_ent;
        ent.touched = i_touch;
        cnt         = 2'd0;
        ev0         = '{kind: KIND_TOUCH, dur: '0};
        ev1         = '{kind: KIND_TOUCH, dur: '0};
        dt_hit      = 1'b0;
        long_hit    = 1'b0;
        if (i_byp) begin
            // raw edges only
            if (i_touch != i_ent.touched) begin
                cnt      = 2'd1;
                ev0.kind = i_touch ? KIND_TOUCH : KIND_RELEASE;
            end
        end else begin
            // touch or release
            if (pressed_now) begin
                ent.pts = i_now;
                cnt     = 2'd1;
                if (i_ent.win && (d_rel <= TGD_TIME_W'(i_cfg.dtap_ms))) begin
                    ev0.kind = KIND_DOUBLE;
                    ent.win  = 1'b0;
                    ent.adt  = 1'b1;
                    dt_hit   = 1'b1;
                end else begin
                    ev0.kind  = KIND_TOUCH;
                    ent.win   = 1'b1;
                    ent.adt   = 1'b0;
                    ent.armed = 1'b1;
                end
            end else if (released_now) begin
                ent.rts = i_now;
                if (i_ent.armed) begin
                    if (d_prs < TGD_TIME_W'(i_cfg.long_ms)) begin
                        if (!i_ent.adt) begin
                            ent.win = 1'b1;
                        end
                    end else begin
                        ent.win = 1'b0;
                    end
                    ent.armed = 1'b0;
                    ent.adt   = 1'b0;
                end
                cnt      = 2'd1;
                ev0.kind = KIND_RELEASE;
            end
            if (!dt_hit) begin
                // long press check
                long_hit = i_touch && ent.armed && (held >= TGD_TIME_W'(i_cfg.long_ms));
                if (long_hit) begin
                    if (cnt == 2'd0) begin
                        ev0 = '{kind: KIND_LONG, dur: held};
                    end else begin
                        ev1 = '{kind: KIND_LONG, dur: held};
                    end
                    cnt       = cnt + 2'd1;
                    ent.armed = 1'b0;
                    ent.win   = 1'b0;
                end
                // double tap window expiry
                if (ent.win && !i_touch && (gap > TGD_TIME_W'(i_cfg.dtap_ms))) begin
                    ent.win = 1'b0;
                    ent.adt = 1'b0;
                end
            end
        end
    end

    assign o_ent    = ent;
    assign o_ev_cnt = cnt;
    assign o_ev0    = ev0;
    assign o_ev1    = ev1;

endmodule

>>> rtl/core/tgd_emit.sv
// event hold stage and output register; marks the final event of each sample
module tgd_emit
    import tgd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_tok   i_tok,
    output logic   o_tok_ready,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_event o_ev,
    output logic   o_last
);

    logic   r_h_vld;
    t_event r_h_ev;
    logic   r_o_vld;
    t_event r_o_ev;
    logic   r_o_last;
    logic   o_free;
    logic   tok_fire;
    logic   push;

    assign o_free      = !r_o_vld || i_out_ready;
    assign o_tok_ready = !r_h_vld || o_free;
    assign tok_fire    = i_tok.vld && o_tok_ready;
    assign push        = tok_fire && r_h_vld;

    // hold register: an event waits here until the next event or the end of its sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else if (tok_fire) begin
            r_h_vld <= !i_tok.eoi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tok_fire && !i_tok.eoi) begin
            r_h_ev <= i_tok.ev;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (push) begin
            r_o_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_o_ev   <= r_h_ev;
            r_o_last <= i_tok.eoi;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_ev        = r_o_ev;
    assign o_last      = r_o_last;

endmodule

>>> rtl/core/touch_gesture_detector.sv
// touch gesture detector top level: config registers, channel sequencer, state memory stage
//
// Each enabled sample is walked channel by channel through one read-modify-write of the
// channel state memory per cycle unless the channel stage stalls; events leave one per
// cycle through an output register unless the output stalls. A channel with two events
// in one sample (touch and long press with a zero long press time) passes them in turn
// before its entry is written back; a sample for a disabled sensor walks no channels.
// The next sample is taken in the cycle the current one closes. The rate is set by the
// single state memory port and the one-event-per-cycle output. No clearing pass is needed
// after reset: per-entry valid flags make untouched entries read as zero. The user must
// write configuration only while no sample is in flight; the block does not enforce it.
module touch_gesture_detector
    import tgd_pkg::*;
#(
    parameter int SENSOR_COUNT      = TGD_SENSOR_COUNT,
    parameter int CHANNELS_PER_UNIT = TGD_CHANNELS_PER_UNIT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [TGD_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TGD_BYPASS_W-1:0]  i_cfg_data,
    // samples
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [TGD_SENSOR_W-1:0]  i_sensor_index,
    input  logic [TGD_MASK_W-1:0]    i_touch_mask,
    input  logic [TGD_TIME_W-1:0]    i_now_ms,
    // events
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [TGD_SENSOR_W-1:0]  o_event_sensor,
    output logic [TGD_CHAN_W-1:0]    o_event_channel,
    output logic [1:0]               o_event_kind,
    output logic [TGD_TIME_W-1:0]    o_press_duration,
    output logic                     o_last_event
);

    localparam int TOTAL  = SENSOR_COUNT * CHANNELS_PER_UNIT;
    localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int CNT_W  = $clog2(CHANNELS_PER_UNIT + 1);
    localparam int CIDX_W = (CHANNELS_PER_UNIT > 1) ? $clog2(CHANNELS_PER_UNIT) : 1;
    localparam int BEXT_W = (TOTAL > TGD_BYPASS_W) ? TOTAL : TGD_BYPASS_W;
    localparam int MEXT_W = (CHANNELS_PER_UNIT > TGD_MASK_W) ? CHANNELS_PER_UNIT : TGD_MASK_W;

    // configuration registers
    logic [TGD_MS_W-1:0]     r_long_ms;
    logic [TGD_MS_W-1:0]     r_dtap_ms;
    logic [TGD_MS_W-1:0]     r_deb_ms;
    logic [TGD_BYPASS_W-1:0] r_bypass;
    logic [TGD_EN_W-1:0]     r_sen_en;
    logic                    cfg_wr;
    logic                    byp_wr;
    logic [BEXT_W-1:0]       cfg_data_ext;
    logic [BEXT_W-1:0]       bypass_ext;
    logic [TOTAL-1:0]        cfg_byp_bit;
    logic [TOTAL-1:0]        byp_vec;
    t_gest_cfg               gcfg;

    // sequencer
    logic                    r_busy;
    logic [CNT_W-1:0]        r_chan;
    logic [TGD_SENSOR_W-1:0] r_sensor;
    logic [TGD_MASK_W-1:0]   r_mask;
    logic [TGD_TIME_W-1:0]   r_now;
    logic [MEXT_W-1:0]       mask_ext;
    logic [CHANNELS_PER_UNIT-1:0] touch_vec;
    logic                    in_acc;
    logic                    sample_ok;
    logic                    issue;
    logic                    issue_end;
    logic                    issue_rd;
    logic [ADDR_W-1:0]       issue_addr;

    // channel stage
    logic                    r_s1_vld;
    logic                    r_s1_eoi;
    logic                    r_s1_sub;
    logic [ADDR_W-1:0]       r_s1_addr;
    logic [TGD_CHAN_W-1:0]   r_s1_chan;
    logic [TGD_SENSOR_W-1:0] r_s1_sensor;
    logic                    r_s1_touch;
    logic [TGD_TIME_W-1:0]   r_s1_now;
    logic [TOTAL-1:0]        r_entry_vld;
    logic [TOTAL-1:0]        r_flag_clr;
    t_entry                  mem_rd;
    t_entry                  ent_in;
    t_entry                  ent_out;
    logic [1:0]              ev_cnt;
    t_evk                    ev0;
    t_evk                    ev1;
    logic                    s1_evt;
    logic                    s1_fire;
    logic                    s1_last;
    logic                    s1_done;
    logic                    st1_free;
    logic                    mem_we;
    t_tok                    tok;
    logic                    tok_ready;
    t_event                  out_ev;

    // configuration writes
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign byp_wr      = cfg_wr && (t_cfg_idx'(i_cfg_index) == CFG_BYPASS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ms <= TGD_LONG_PRESS_RST;
            r_dtap_ms <= TGD_DOUBLE_TAP_RST;
            r_deb_ms  <= TGD_DEBOUNCE_RST;
            r_bypass  <= '0;
            r_sen_en  <= '0;
        end else if (cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LONG_PRESS: r_long_ms <= i_cfg_data[TGD_MS_W-1:0];
                CFG_DOUBLE_TAP: r_dtap_ms <= i_cfg_data[TGD_MS_W-1:0];
                CFG_DEBOUNCE:   r_deb_ms  <= i_cfg_data[TGD_MS_W-1:0];
                CFG_BYPASS:     r_bypass  <= i_cfg_data;
                CFG_SENSOR_EN:  r_sen_en  <= i_cfg_data[TGD_EN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign gcfg = '{long_ms: r_long_ms, dtap_ms: r_dtap_ms, deb_ms: r_deb_ms};

    // bypass bits per state entry; entries past the bypass register width are never bypassed
    assign cfg_data_ext = BEXT_W'(i_cfg_data);
    assign bypass_ext   = BEXT_W'(r_bypass);
    assign cfg_byp_bit  = cfg_data_ext[TOTAL-1:0];
    assign byp_vec      = bypass_ext[TOTAL-1:0];

    // touch bit per channel; channels past the mask width read untouched
    assign mask_ext  = MEXT_W'(r_mask);
    assign touch_vec = mask_ext[CHANNELS_PER_UNIT-1:0];

    // sample intake
    assign sample_ok  = (32'(i_sensor_index) < SENSOR_COUNT) && r_sen_en[i_sensor_index];
    assign issue      = r_busy && st1_free;
    assign issue_end  = issue && (r_chan == CNT_W'(CHANNELS_PER_UNIT));
    assign issue_rd   = issue && !issue_end;
    assign o_in_ready = !r_busy || issue_end;
    assign in_acc     = i_in_valid && o_in_ready;
    assign issue_addr = ADDR_W'(32'(r_sensor) * CHANNELS_PER_UNIT + 32'(r_chan));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_chan <= '0;
        end else begin
            if (in_acc) begin
                r_busy <= sample_ok;
                r_chan <= '0;
            end else if (issue_end) begin
                r_busy <= 1'b0;
            end else if (issue_rd) begin
                r_chan <= r_chan + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sensor <= i_sensor_index;
            r_mask   <= i_touch_mask;
            r_now    <= i_now_ms;
        end
    end

    // channel stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s1_sub <= 1'b0;
        end else begin
            if (issue) begin
                r_s1_vld <= 1'b1;
            end else if (s1_done) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_done) begin
                r_s1_sub <= 1'b0;
            end else if (s1_fire) begin
                r_s1_sub <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_eoi    <= issue_end;
            r_s1_addr   <= issue_addr;
            r_s1_chan   <= TGD_CHAN_W'(r_chan[CIDX_W-1:0]);
            r_s1_sensor <= r_sensor;
            r_s1_touch  <= touch_vec[r_chan[CIDX_W-1:0]];
            r_s1_now    <= r_now;
        end
    end

    // entry valid flags and pending flag clears from bypass writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_vld <= '0;
            r_flag_clr  <= '0;
        end else begin
            for (int i = 0; i < TOTAL; i++) begin
                if (mem_we && (r_s1_addr == ADDR_W'(i))) begin
                    r_entry_vld[i] <= 1'b1;
                    r_flag_clr[i]  <= 1'b0;
                end else if (byp_wr && cfg_byp_bit[i]) begin
                    r_flag_clr[i] <= 1'b1;
                end
            end
        end
    end

    tgd_mem #(
        .DEPTH  (TOTAL),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_re    (issue_rd),
        .i_raddr (issue_addr),
        .i_we    (mem_we),
        .i_waddr (r_s1_addr),
        .i_wdata (ent_out),
        .o_rdata (mem_rd)
    );

    // entry as seen after reset and bypass clears
    always_comb begin
        ent_in = r_entry_vld[r_s1_addr] ? mem_rd : '0;
        if (r_flag_clr[r_s1_addr]) begin
            ent_in.armed = 1'b0;
            ent_in.win   = 1'b0;
            ent_in.adt   = 1'b0;
        end
    end

    tgd_chan u_chan (
        .i_ent    (ent_in),
        .i_touch  (r_s1_touch),
        .i_byp    (byp_vec[r_s1_addr]),
        .i_now    (r_s1_now),
        .i_cfg    (gcfg),
        .o_ent    (ent_out),
        .o_ev_cnt (ev_cnt),
        .o_ev0    (ev0),
        .o_ev1    (ev1)
    );

    // one event per cycle unless the emitter stalls; entry written back on the last step
    assign s1_evt   = !r_s1_eoi && (ev_cnt > {1'b0, r_s1_sub});
    assign tok.vld  = r_s1_vld && (r_s1_eoi || s1_evt);
    assign tok.eoi  = r_s1_eoi;
    assign tok.ev   = '{sensor:  r_s1_sensor,
                        channel: r_s1_chan,
                        kind:    r_s1_sub ? ev1.kind : ev0.kind,
                        dur:     r_s1_sub ? ev1.dur  : ev0.dur};
    assign s1_fire  = r_s1_vld && (!tok.vld || tok_ready);
    assign s1_last  = r_s1_eoi || r_s1_sub || (ev_cnt != 2'd2);
    assign s1_done  = s1_fire && s1_last;
    assign st1_free = !r_s1_vld || s1_done;
    assign mem_we   = s1_done && !r_s1_eoi;

    tgd_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (tok),
        .o_tok_ready (tok_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ev        (out_ev),
        .o_last      (o_last_event)
    );

    assign o_event_sensor   = out_ev.sensor;
    assign o_event_channel  = out_ev.channel;
    assign o_event_kind     = out_ev.kind;
    assign o_press_duration = out_ev.dur;

endmodule

>>> rtl/core/tgd_checker.sv
// port-level checks of the touch gesture detector and their binding
module tgd_checker
    import tgd_pkg::*;
#(
    parameter int CHANNELS_PER_UNIT = TGD_CHANNELS_PER_UNIT
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [TGD_CHAN_W-1:0]   o_event_channel,
    input logic [1:0]              o_event_kind,
    input logic [TGD_TIME_W-1:0]   o_press_duration,
    input logic                    o_last_event
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_event_kind)
            && $stable(o_press_duration) && $stable(o_last_event))
        else $error("output item changed while stalled");

    // no item right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // duration only on long press
    a_dur_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_kind == KIND_LONG) || (o_press_duration == '0))
        else $error("duration on a non long press item");

    // channel in range
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_event_channel) < CHANNELS_PER_UNIT))
        else $error("event channel out of range");

endmodule

bind touch_gesture_detector tgd_checker #(
    .CHANNELS_PER_UNIT (CHANNELS_PER_UNIT)
) u_tgd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_event_channel  (o_event_channel),
    .o_event_kind     (o_event_kind),
    .o_press_duration (o_press_duration),
    .o_last_event     (o_last_event)
);
